### rtl/core/min_priority_queue_top_defines.svh
// Assertion macros shared by the priority queue RTL.
`ifndef MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define MPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpq: same-cycle check failed");

// Next-cycle implication, checked on every clock outside reset.
`define MPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpq: next-cycle check failed");

`endif

### rtl/core/mpq_pkg.sv
// Types and constants of the sorted-list priority queue.
package mpq_pkg;

	// Fixed widths of the word fields
	localparam int JOB_BITS  = 16;
	localparam int TIME_BITS = 16;

	// Operation codes on func
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} mpq_ctl_t;

endpackage

### rtl/core/mpq_cell.sv
// One cell of the sorted chain: holds one entry and trades with its neighbors.
module mpq_cell #(
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mpq_pkg::mpq_ctl_t            ctl,
	input  logic [mpq_pkg::JOB_BITS-1:0] new_job,
	input  logic [KEY_BITS-1:0]          new_time,
	input  logic                         left_stay,
	input  logic                         left_valid,
	input  logic [mpq_pkg::JOB_BITS-1:0] left_job,
	input  logic [KEY_BITS-1:0]          left_time,
	input  logic                         right_valid,
	input  logic [mpq_pkg::JOB_BITS-1:0] right_job,
	input  logic [KEY_BITS-1:0]          right_time,
	output logic                         stay,
	output logic                         valid,
	output logic [mpq_pkg::JOB_BITS-1:0] job,
	output logic [KEY_BITS-1:0]          key
);

	logic                         valid_q;
	logic [mpq_pkg::JOB_BITS-1:0] job_q;
	logic [KEY_BITS-1:0]          time_q;
	logic                         take_new;

	// Entry stays put on insert when it sorts at or ahead of the new key
	assign stay     = valid_q && (time_q <= new_time);
	// First cell that does not stay receives the new word
	assign take_new = !stay && left_stay;

	// Occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !stay) begin
			valid_q <= take_new ? 1'b1 : left_valid;
		end else if (ctl.del) begin
			valid_q <= right_valid;
		end
	end

	// Entry payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.ins && !stay) begin
			job_q  <= take_new ? new_job : left_job;
			time_q <= take_new ? new_time : left_time;
		end else if (ctl.del) begin
			job_q  <= right_job;
			time_q <= right_time;
		end
	end

	assign valid = valid_q;
	assign job   = job_q;
	assign key   = time_q;

endmodule

### rtl/core/min_priority_queue_top.sv
// Sorted-list min-priority queue built from a chain of compare-and-shift cells.
// The result word is registered: it appears in the cycle after the command is taken.
// Throughput: one insert or delete per cycle while busy is low; every cell compares and shifts in parallel.
// Reset: arst_n clears all occupancy bits and the strobe; busy is high in reset
// and until its register is clocked after it, then stays low. The result strobe cannot be stalled.
`include "min_priority_queue_top_defines.svh"

module min_priority_queue_top #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [mpq_pkg::JOB_BITS-1:0]  job_id,
	input  logic [mpq_pkg::TIME_BITS-1:0] job_time,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [mpq_pkg::JOB_BITS-1:0]  out_job,
	output logic [mpq_pkg::TIME_BITS-1:0] out_time
);

	logic                         busy_q;
	logic                         accept;
	logic                         full;
	logic                         empty;
	logic                         underflow;
	logic [KEY_BITS-1:0]          new_key;
	mpq_pkg::mpq_ctl_t            ctl;
	logic [CAPACITY-1:0]          valid;
	logic [CAPACITY-1:0]          stay;
	logic [mpq_pkg::JOB_BITS-1:0] job   [CAPACITY];
	logic [KEY_BITS-1:0]          key   [CAPACITY];
	logic                         done_q;
	mpq_pkg::status_t             status_q;
	logic [mpq_pkg::JOB_BITS-1:0] out_job_q;
	logic [mpq_pkg::TIME_BITS-1:0] out_time_q;
	logic [mpq_pkg::TIME_BITS-1:0] head_time;

	// Key is job_time cut or zero-extended to KEY_BITS; head key back to the 16-bit field
	generate
		if (KEY_BITS == mpq_pkg::TIME_BITS) begin : g_key_same
			assign new_key   = job_time;
			assign head_time = key[0];
		end else if (KEY_BITS < mpq_pkg::TIME_BITS) begin : g_key_narrow
			assign new_key   = job_time[KEY_BITS-1:0];
			assign head_time = {{(mpq_pkg::TIME_BITS-KEY_BITS){1'b0}}, key[0]};
		end else begin : g_key_wide
			assign new_key = {{(KEY_BITS-mpq_pkg::TIME_BITS){1'b0}}, job_time};
			assign head_time = key[0][mpq_pkg::TIME_BITS-1:0];
		end
	endgenerate

	// Command decode
	assign accept    = start && !busy_q;
	assign full      = valid[CAPACITY-1];
	assign empty     = !valid[0];
	assign ctl.ins   = accept && (func == mpq_pkg::FUNC_INSERT) && !full;
	assign ctl.del   = accept && (func == mpq_pkg::FUNC_DELETE) && !empty;
	assign underflow = accept && (func == mpq_pkg::FUNC_DELETE) && empty;

	// Busy only while leaving reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Cell chain; index 0 is the head
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic                         l_stay;
			logic                         l_valid;
			logic [mpq_pkg::JOB_BITS-1:0] l_job;
			logic [KEY_BITS-1:0]          l_time;
			logic                         r_valid;
			logic [mpq_pkg::JOB_BITS-1:0] r_job;
			logic [KEY_BITS-1:0]          r_time;

			if (i == 0) begin : g_head
				assign l_stay  = 1'b1;
				assign l_valid = 1'b0;
				assign l_job   = '0;
				assign l_time  = '0;
			end else begin : g_mid
				assign l_stay  = stay[i-1];
				assign l_valid = valid[i-1];
				assign l_job   = job[i-1];
				assign l_time  = key[i-1];
			end

			if (i == CAPACITY-1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_job   = '0;
				assign r_time  = '0;
			end else begin : g_body
				assign r_valid = valid[i+1];
				assign r_job   = job[i+1];
				assign r_time  = key[i+1];
			end

			mpq_cell #(
				.KEY_BITS(KEY_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.new_job    (job_id),
				.new_time   (new_key),
				.left_stay  (l_stay),
				.left_valid (l_valid),
				.left_job   (l_job),
				.left_time  (l_time),
				.right_valid(r_valid),
				.right_job  (r_job),
				.right_time (r_time),
				.stay       (stay[i]),
				.valid      (valid[i]),
				.job        (job[i]),
				.key        (key[i])
			);
		end
	endgenerate

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (accept) begin
			if (func == mpq_pkg::FUNC_INSERT) begin
				status_q <= full ? mpq_pkg::ST_OVERFLOW : mpq_pkg::ST_INSERTED;
			end else begin
				status_q <= empty ? mpq_pkg::ST_UNDERFLOW : mpq_pkg::ST_REMOVED;
			end
			out_job_q  <= ctl.del ? job[0] : '0;
			out_time_q <= ctl.del ? head_time : '0;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign status   = status_q;
	assign out_job  = out_job_q;
	assign out_time = out_time_q;

	// Checks
	`MPQ_ASSERT_NOW(a_occupancy_prefix, 1'b1, ((valid & ~{valid[CAPACITY-2:0], 1'b1}) == '0))
	`MPQ_ASSERT_NEXT(a_strobe_follows, accept, done)
	`MPQ_ASSERT_NEXT(a_underflow, underflow, (status == mpq_pkg::ST_UNDERFLOW))
	`MPQ_ASSERT_NOW(a_head_sorted, valid[1], (key[0] <= key[1]))

endmodule

### tb/mpq_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted-list priority queue: predicts each result word and compares it.
module mpq_checker #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          func,
	input  logic [mpq_pkg::JOB_BITS-1:0]  job_id,
	input  logic [mpq_pkg::TIME_BITS-1:0] job_time,
	input  logic                          done,
	input  logic [1:0]                    status,
	input  logic [mpq_pkg::JOB_BITS-1:0]  out_job,
	input  logic [mpq_pkg::TIME_BITS-1:0] out_time,
	output int                            mismatches,
	output int                            words_due
);

	// Keys wider than KEY_BITS lose their high bits
	localparam logic [mpq_pkg::TIME_BITS-1:0] KEY_MASK =
		(KEY_BITS >= mpq_pkg::TIME_BITS) ? '1 :
		mpq_pkg::TIME_BITS'((1 << KEY_BITS) - 1);

	typedef struct packed {
		mpq_pkg::status_t              st;
		logic [mpq_pkg::JOB_BITS-1:0]  job;
		logic [mpq_pkg::TIME_BITS-1:0] tm;
	} reply_t;

	// Shadow copy of the sorted list, head at index 0
	logic [mpq_pkg::JOB_BITS-1:0]  slot_job [CAPACITY];
	logic [mpq_pkg::TIME_BITS-1:0] slot_time[CAPACITY];
	int                            held;
	int                            pos;
	int                            fails;
	logic [mpq_pkg::TIME_BITS-1:0] key;
	reply_t                        want;
	reply_t                        replies_pending[$];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			fails = 0;
			replies_pending.delete();
			mismatches <= 0;
			words_due <= 0;
		end else begin
			// compare a result word with the oldest prediction
			if (done) begin
				if (replies_pending.size() == 0) begin
					$error("result word with no command waiting: status %0d", status);
					fails++;
				end else begin
					want = replies_pending.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fails++;
					end
					if (out_job !== want.job) begin
						$error("out_job: expected %0d, got %0d", want.job, out_job);
						fails++;
					end
					if (out_time !== want.tm) begin
						$error("out_time: expected %0d, got %0d", want.tm, out_time);
						fails++;
					end
				end
			end

			// predict the word for a command taken at this edge
			if (start && !busy) begin
				want = '{st: mpq_pkg::ST_INSERTED, job: '0, tm: '0};
				if (func == mpq_pkg::FUNC_INSERT) begin
					if (held >= CAPACITY) begin
						want.st = mpq_pkg::ST_OVERFLOW;
					end else begin
						// new entry goes behind every entry with a key not above its own
						key = job_time & KEY_MASK;
						pos = 0;
						while (pos < held && slot_time[pos] <= key)
							pos++;
						for (int i = held; i > pos; i--) begin
							slot_job[i] = slot_job[i-1];
							slot_time[i] = slot_time[i-1];
						end
						slot_job[pos] = job_id;
						slot_time[pos] = key;
						held++;
					end
				end else begin
					if (held == 0) begin
						want.st = mpq_pkg::ST_UNDERFLOW;
					end else begin
						// pop the head and close the gap
						want.st = mpq_pkg::ST_REMOVED;
						want.job = slot_job[0];
						want.tm = slot_time[0];
						for (int i = 1; i < held; i++) begin
							slot_job[i-1] = slot_job[i];
							slot_time[i-1] = slot_time[i];
						end
						held--;
					end
				end
				replies_pending.push_back(want);
			end

			mismatches <= fails;
			words_due <= replies_pending.size();
		end
	end

endmodule

### tb/min_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the priority queue: clock, reset, command stimulus and verdict.
module min_priority_queue_top_tb;

	localparam int CAPACITY       = 16;
	localparam int KEY_BITS       = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 650;
	localparam int BURST_WORDS    = 40;

	// Keys of the directed fill, first entry in the top slice
	localparam logic [16*mpq_pkg::TIME_BITS-1:0] LOAD_TIMES = {
		16'hFFFF, 16'h0000, 16'h0064, 16'h0064, 16'h0064, 16'h0032, 16'h0000, 16'hFFFF,
		16'h00C8, 16'h7FFF, 16'h8000, 16'h0001, 16'h0063, 16'h0065, 16'h0064, 16'h0000
	};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          func;
	logic [mpq_pkg::JOB_BITS-1:0]  job_id;
	logic [mpq_pkg::TIME_BITS-1:0] job_time;
	logic                          done;
	logic [1:0]                    status;
	logic [mpq_pkg::JOB_BITS-1:0]  out_job;
	logic [mpq_pkg::TIME_BITS-1:0] out_time;
	int                            mismatches;
	int                            words_due;
	int                            quiet_cycles;

	min_priority_queue_top #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.job_id(job_id),
		.job_time(job_time),
		.done(done),
		.status(status),
		.out_job(out_job),
		.out_time(out_time)
	);

	mpq_checker #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) score (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.job_id(job_id),
		.job_time(job_time),
		.done(done),
		.status(status),
		.out_job(out_job),
		.out_time(out_time),
		.mismatches(mismatches),
		.words_due(words_due)
	);

	// 50 MHz clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: no command taken and no result for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Issue one command word after a random gap; returns at the edge that takes it
	task automatic issue(input logic f, input logic [mpq_pkg::JOB_BITS-1:0] id,
			input logic [mpq_pkg::TIME_BITS-1:0] t, input int gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start = 1'b0;
			func = 1'($urandom);
			job_id = mpq_pkg::JOB_BITS'($urandom);
			job_time = mpq_pkg::TIME_BITS'($urandom);
		end
		@(negedge clk);
		start = 1'b1;
		func = f;
		job_id = id;
		job_time = t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Hold off until every predicted word has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Keys: clustered in 0..7 four times in ten so equal keys are common, extremes one in ten, rest anywhere
	function automatic logic [mpq_pkg::TIME_BITS-1:0] pick_key();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return mpq_pkg::TIME_BITS'($urandom_range(7));
		else if (sel == 4)
			return $urandom_range(1) ? '1 : '0;
		else
			return mpq_pkg::TIME_BITS'($urandom);
	endfunction

	initial begin
		int gap_pct;
		int ins_pct;
		arst_n = 1'b0;
		start = 1'b0;
		func = mpq_pkg::FUNC_INSERT;
		job_id = '0;
		job_time = '0;
		ins_pct = 50;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: delete when empty, fill with extreme and equal keys, overflow, three deletes
		issue(mpq_pkg::FUNC_DELETE, '1, '1, 0);
		for (int i = 0; i < CAPACITY; i++)
			issue(mpq_pkg::FUNC_INSERT, (i == 1) ? '1 : mpq_pkg::JOB_BITS'(i),
				LOAD_TIMES[(15 - i)*mpq_pkg::TIME_BITS +: mpq_pkg::TIME_BITS], 0);
		issue(mpq_pkg::FUNC_INSERT, 16'hAAAA, 16'h5555, 0);
		repeat (3) issue(mpq_pkg::FUNC_DELETE, 16'h5A5A, 16'hA5A5, 0);
		drain();

		// random: bursts leaning to insert or delete so the list fills and empties
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 15 : (phase == 1) ? 52 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % BURST_WORDS == 0)
					ins_pct = $urandom_range(85, 15);
				if ($urandom_range(99) < ins_pct)
					issue(mpq_pkg::FUNC_INSERT, mpq_pkg::JOB_BITS'($urandom), pick_key(),
						gap_pct);
				else
					issue(mpq_pkg::FUNC_DELETE, mpq_pkg::JOB_BITS'($urandom),
						mpq_pkg::TIME_BITS'($urandom), gap_pct);
			end
			drain();
		end

		// verdict
		repeat (3) @(negedge clk);
		if (mismatches == 0 && words_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue_top.sv
tb/mpq_checker.sv
tb/min_priority_queue_top_tb.sv
